// ===== hw/rtl/tvf_pkg.sv =====
package tvf_pkg;

   // Fixed field widths of the event and result beats and of the CSR port
   localparam int ACTION_BITS    = 3;
   localparam int CHAN_BITS      = 16;
   localparam int FREQ_FIELD_BITS = 32;
   localparam int SLOT_BITS      = 2;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Defaults for the top-level parameters
   localparam int TIMER_BITS_DEF = 16;
   localparam int FREQ_BITS_DEF  = 32;

   // Register reset values, in ticks
   localparam logic [CFG_BITS-1:0] HANG_TICKS_RST    = 16'd10;
   localparam logic [CFG_BITS-1:0] GRACE_TICKS_RST   = 16'd15;
   localparam logic [CFG_BITS-1:0] DWELL_TICKS_RST   = 16'd7;
   localparam logic [CFG_BITS-1:0] GRANT_TO_TICKS_RST = 16'd40;
   localparam logic [CFG_BITS-1:0] BACKOFF_TICKS_RST = 16'd10;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_TICK  = 3'd0,
      ACT_GRANT = 3'd1,
      ACT_VOICE = 3'd2,
      ACT_QUIET = 3'd3,
      ACT_SYNC_LOST = 3'd4
   } act_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_ARMED  = 2'd1,
      MODE_FOLLOW = 2'd2,
      MODE_HANG   = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HANG_TICKS     = 3'd0,
      CSR_GRACE_TICKS    = 3'd1,
      CSR_DWELL_TICKS    = 3'd2,
      CSR_GRANT_TO_TICKS = 3'd3,
      CSR_BACKOFF_TICKS  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0]     action;
      logic [CHAN_BITS-1:0]       channel;
      logic [FREQ_FIELD_BITS-1:0] freq;
      logic [SLOT_BITS-1:0]       slot;
   } req_type;

   typedef struct packed {
      logic [1:0]                 mode;
      logic                       mode_changed;
      logic                       tune_request;
      logic [FREQ_FIELD_BITS-1:0] tune_freq;
      logic [CHAN_BITS-1:0]       tune_channel;
      logic                       returned_to_cc;
      logic                       grant_ignored;
   } rsp_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] hang_ticks;
      logic [CFG_BITS-1:0] grace_ticks;
      logic [CFG_BITS-1:0] dwell_ticks;
      logic [CFG_BITS-1:0] grant_timeout_ticks;
      logic [CFG_BITS-1:0] backoff_ticks;
   } cfg_type;

endpackage

// ===== hw/rtl/trunk_voice_follow_fsm_core.sv =====
// Two-slot trunked voice-channel follow controller. Each req beat carries one
// event (tick, grant, voice, quiet, sync lost); each event yields exactly one
// rsp beat with the new mode and any tune, release or grant-ignored flags.
// An event lands in an input register, is evaluated against the controller
// state once the output register is free or being drained, and its result is
// held in the output register, which drives rsp_valid. One event per cycle is
// sustained while rsp_stall stays low. Evaluation is a single combinational
// pass in tvf_engine (timer advance, timeout compares and mode update). Timers
// saturate at 2**TIMER_BITS-1 ticks; frequencies are kept to FREQ_BITS bits.
// Write the csr_ registers only while no event is in flight.
module trunk_voice_follow_fsm_core #(
   parameter int TIMER_BITS = tvf_pkg::TIMER_BITS_DEF,
   parameter int FREQ_BITS  = tvf_pkg::FREQ_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tvf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tvf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [tvf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tvf_pkg::CFG_BITS-1:0]        csr_wdata
);
   import tvf_pkg::*;

   cfg_type cfg;

   // Input stage: one event beat waiting for evaluation
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   // Output stage: one result beat waiting for the consumer
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type result;

   logic advance;
   logic req_take;

   tvf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tvf_engine #(
      .TIMER_BITS (TIMER_BITS),
      .FREQ_BITS  (FREQ_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Advance the held event whenever the output slot is free or being drained
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // Stall upstream only while the held event cannot move on
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !advance);
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // A tune request only comes from an accepted grant, which arms the channel
   a_tune_armed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tune_request |-> rsp_data.mode == MODE_ARMED)
      else $error("tune request without armed mode");

   // A release always drops to idle from a busy mode
   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.returned_to_cc
      |-> rsp_data.mode == MODE_IDLE && rsp_data.mode_changed)
      else $error("release did not return to idle");

   // An ignored grant leaves everything untouched
   a_ignore_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.grant_ignored
      |-> !rsp_data.tune_request && !rsp_data.mode_changed && !rsp_data.returned_to_cc)
      else $error("ignored grant changed state");

   // The output stage is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

// ===== hw/rtl/tvf_csr.sv =====
module tvf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tvf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tvf_pkg::CFG_BITS-1:0]        csr_wdata,
   output tvf_pkg::cfg_type                    cfg
);
   import tvf_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HANG_TICKS:     cfg_in.hang_ticks          = csr_wdata;
            CSR_GRACE_TICKS:    cfg_in.grace_ticks         = csr_wdata;
            CSR_DWELL_TICKS:    cfg_in.dwell_ticks         = csr_wdata;
            CSR_GRANT_TO_TICKS: cfg_in.grant_timeout_ticks = csr_wdata;
            CSR_BACKOFF_TICKS:  cfg_in.backoff_ticks       = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hang_ticks          <= HANG_TICKS_RST;
         cfg_ff.grace_ticks         <= GRACE_TICKS_RST;
         cfg_ff.dwell_ticks         <= DWELL_TICKS_RST;
         cfg_ff.grant_timeout_ticks <= GRANT_TO_TICKS_RST;
         cfg_ff.backoff_ticks       <= BACKOFF_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/tvf_engine.sv =====
module tvf_engine #(
   parameter int TIMER_BITS = tvf_pkg::TIMER_BITS_DEF,
   parameter int FREQ_BITS  = tvf_pkg::FREQ_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  tvf_pkg::req_type item,
   input  tvf_pkg::cfg_type cfg,
   output tvf_pkg::rsp_type result
);
   import tvf_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
   localparam int FW = (FREQ_BITS > FREQ_FIELD_BITS) ? FREQ_BITS : FREQ_FIELD_BITS;

   typedef logic [TIMER_BITS-1:0] tmr_type;
   typedef logic [FREQ_BITS-1:0]  frq_type;

   function automatic tmr_type adv(input tmr_type t);
      return (t == '1) ? t : t + tmr_type'(1);
   endfunction

   function automatic logic expired(input logic seen, input tmr_type t,
                                    input logic [CFG_BITS-1:0] lim);
      return !seen || (CMP_BITS'(t) >= CMP_BITS'(lim));
   endfunction

   mode_type mode_ff, mode_in;
   logic [1:0] busy_ff, busy_in;
   frq_type call_freq_ff, call_freq_in, rel_freq_ff, rel_freq_in;
   tmr_type tune_t_ff, tune_t_in, voice_t_ff, voice_t_in, hang_t_ff, hang_t_in;
   tmr_type follow_t_ff, follow_t_in, rel_t_ff, rel_t_in;
   logic tune_seen_ff, tune_seen_in, voice_seen_ff, voice_seen_in;
   logic hang_seen_ff, hang_seen_in, follow_seen_ff, follow_seen_in;
   logic rel_seen_ff, rel_seen_in;

   frq_type freq_f;
   tmr_type fol_t;
   logic    do_release;
   logic    ignore;
   logic [1:0] quiet_busy;

   assign freq_f = FREQ_BITS'(FW'(item.freq));

   always_comb begin
      mode_in        = mode_ff;
      busy_in        = busy_ff;
      call_freq_in   = call_freq_ff;
      rel_freq_in    = rel_freq_ff;
      tune_t_in      = tune_t_ff;
      voice_t_in     = voice_t_ff;
      hang_t_in      = hang_t_ff;
      follow_t_in    = follow_t_ff;
      rel_t_in       = rel_t_ff;
      tune_seen_in   = tune_seen_ff;
      voice_seen_in  = voice_seen_ff;
      hang_seen_in   = hang_seen_ff;
      follow_seen_in = follow_seen_ff;
      rel_seen_in    = rel_seen_ff;
      do_release     = 1'b0;
      fol_t          = '0;
      quiet_busy     = busy_ff;
      ignore         = 1'b0;
      result         = '0;

      case (item.action)
         ACT_TICK: begin
            tune_t_in   = adv(tune_t_ff);
            voice_t_in  = adv(voice_t_ff);
            hang_t_in   = adv(hang_t_ff);
            follow_t_in = adv(follow_t_ff);
            rel_t_in    = adv(rel_t_ff);
            fol_t       = follow_seen_ff ? follow_t_in : '0;
            unique case (mode_ff)
               MODE_ARMED:
                  do_release = expired(tune_seen_ff, tune_t_in, cfg.grant_timeout_ticks)
                               && (busy_ff == 2'b00);
               MODE_FOLLOW:
                  do_release = expired(tune_seen_ff, tune_t_in, cfg.grace_ticks)
                               && expired(voice_seen_ff, voice_t_in, cfg.hang_ticks)
                               && (CMP_BITS'(fol_t) >= CMP_BITS'(cfg.dwell_ticks))
                               && (busy_ff == 2'b00);
               MODE_HANG:
                  do_release = expired(hang_seen_ff, hang_t_in, cfg.hang_ticks);
               MODE_IDLE:
                  do_release = 1'b0;
               default:
                  do_release = 1'b0;
            endcase
         end
         ACT_GRANT: begin
            ignore = rel_seen_ff && (rel_freq_ff != '0) && (freq_f != '0)
                     && (freq_f == rel_freq_ff)
                     && (CMP_BITS'(rel_t_ff) < CMP_BITS'(cfg.backoff_ticks));
            if (!ignore) begin
               call_freq_in  = freq_f;
               tune_t_in     = '0;
               tune_seen_in  = 1'b1;
               voice_t_in    = '0;
               voice_seen_in = 1'b0;
               busy_in       = 2'b00;
               mode_in       = MODE_ARMED;
               if (freq_f != '0) begin
                  result.tune_request = 1'b1;
                  result.tune_freq    = FREQ_FIELD_BITS'(FW'(freq_f));
                  result.tune_channel = item.channel;
               end
            end
         end
         ACT_VOICE: begin
            if (!item.slot[1]) busy_in[item.slot[0]] = 1'b1;
            voice_t_in    = '0;
            voice_seen_in = 1'b1;
            if (mode_ff == MODE_ARMED || mode_ff == MODE_HANG) begin
               mode_in        = MODE_FOLLOW;
               follow_t_in    = '0;
               follow_seen_in = 1'b1;
            end
         end
         ACT_QUIET: begin
            if (!item.slot[1]) quiet_busy[item.slot[0]] = 1'b0;
            busy_in = quiet_busy;
            if (quiet_busy == 2'b00) begin
               hang_t_in    = '0;
               hang_seen_in = 1'b1;
               mode_in      = MODE_HANG;
            end
         end
         ACT_SYNC_LOST: begin
            if ((mode_ff == MODE_FOLLOW || mode_ff == MODE_ARMED)
                && expired(tune_seen_ff, tune_t_ff, cfg.grace_ticks)
                && (busy_ff == 2'b00)) begin
               hang_t_in    = '0;
               hang_seen_in = 1'b1;
               mode_in      = MODE_HANG;
            end
         end
         default: ;
      endcase

      // Drop the call and start the backoff window
      if (do_release) begin
         rel_freq_in    = call_freq_ff;
         rel_t_in       = '0;
         rel_seen_in    = 1'b1;
         call_freq_in   = '0;
         busy_in        = 2'b00;
         tune_seen_in   = 1'b0;
         voice_seen_in  = 1'b0;
         hang_seen_in   = 1'b0;
         follow_seen_in = 1'b0;
         tune_t_in      = '0;
         voice_t_in     = '0;
         hang_t_in      = '0;
         follow_t_in    = '0;
         mode_in        = MODE_IDLE;
      end

      result.mode           = mode_in;
      result.mode_changed   = (mode_in != mode_ff);
      result.returned_to_cc = do_release;
      result.grant_ignored  = ignore;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_IDLE;
         busy_ff        <= 2'b00;
         call_freq_ff   <= '0;
         rel_freq_ff    <= '0;
         tune_t_ff      <= '0;
         voice_t_ff     <= '0;
         hang_t_ff      <= '0;
         follow_t_ff    <= '0;
         rel_t_ff       <= '0;
         tune_seen_ff   <= 1'b0;
         voice_seen_ff  <= 1'b0;
         hang_seen_ff   <= 1'b0;
         follow_seen_ff <= 1'b0;
         rel_seen_ff    <= 1'b0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         busy_ff        <= busy_in;
         call_freq_ff   <= call_freq_in;
         rel_freq_ff    <= rel_freq_in;
         tune_t_ff      <= tune_t_in;
         voice_t_ff     <= voice_t_in;
         hang_t_ff      <= hang_t_in;
         follow_t_ff    <= follow_t_in;
         rel_t_ff       <= rel_t_in;
         tune_seen_ff   <= tune_seen_in;
         voice_seen_ff  <= voice_seen_in;
         hang_seen_ff   <= hang_seen_in;
         follow_seen_ff <= follow_seen_in;
         rel_seen_ff    <= rel_seen_in;
      end
   end

endmodule

// ===== dv/trunk_voice_follow_fsm_core_tb.sv =====
`timescale 1ns / 1ps

module trunk_voice_follow_fsm_core_tb;
   import tvf_pkg::*;

   // Unused action codes; the block must report the current mode and do nothing
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LO  = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_MID = 3'd6;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_HI  = 3'd7;

   // Register map: indexes past the last one are writable but land nowhere
   localparam int CSR_COUNT     = 5;
   localparam int CSR_SPARE_TOP = (1 << CSR_INDEX_BITS) - 1;

   localparam logic [SLOT_BITS-1:0] NO_SLOT = 2'd3;

   localparam int    PHASE_ITEMS   = 210;
   localparam int    DIR_ROWS      = 20;
   localparam int    REPORT_MAX    = 10;
   localparam int    HOLD_CYCLES   = 300;
   localparam int    SETTLE_CYCLES = 8;
   localparam int    DRAIN_LIMIT   = 5000;
   localparam int    BACKOFF_GAP   = 3;
   localparam longint TIMEOUT_NS   = 64'd20 * 64'd1_000_000;

   localparam logic [FREQ_FIELD_BITS-1:0] SAT_FREQ = 32'h1C9C_3800;

   typedef logic [TIMER_BITS_DEF-1:0] tick_t;

   typedef struct {
      logic [ACTION_BITS-1:0]     act;
      logic [CHAN_BITS-1:0]       chan;
      logic [FREQ_FIELD_BITS-1:0] freq;
      logic [SLOT_BITS-1:0]       slot;
      int                         count;
      bit                         typed;
      rsp_type                    want;
   } plan_row;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   // Shadow of the follow controller
   cfg_type                     follow_cfg;
   mode_type                    p_mode;
   logic [1:0]                  p_busy;
   logic [FREQ_BITS_DEF-1:0]    p_call_freq, p_rel_freq;
   tick_t                       t_tune, t_voice, t_hang, t_follow, t_release;
   bit                          seen_tune, seen_voice, seen_hang, seen_follow, seen_release;

   rsp_type     outcome_q[$];
   plan_row     dir_plan[DIR_ROWS];
   int          mismatches    = 0;
   int          sent_in_phase = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   logic        hold_ask      = 1'b0;
   logic        hold_used     = 1'b0;
   int          hold_left     = 0;

   trunk_voice_follow_fsm_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Hard stop in case the block wedges
   initial begin
      #(TIMEOUT_NS);
      $display("trunk_voice_follow_fsm_core_tb failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Follow-controller prediction
   // ------------------------------------------------------------------

   // Saturating advance: a timer parks at all ones
   function automatic tick_t sat_inc(input tick_t t);
      return (t == '1) ? t : t + 1'b1;
   endfunction

   // A timer without its valid bit reads as run out
   function automatic bit lapsed(input bit seen, input tick_t t, input tick_t limit);
      return !seen || t >= limit;
   endfunction

   // Give up the voice channel: remember its frequency for backoff, clear the call
   function automatic void drop_call();
      p_rel_freq   = p_call_freq;
      t_release    = '0;
      seen_release = 1'b1;
      p_call_freq  = '0;
      p_busy       = '0;
      seen_tune    = 1'b0;
      seen_voice   = 1'b0;
      seen_hang    = 1'b0;
      seen_follow  = 1'b0;
      t_tune       = '0;
      t_voice      = '0;
      t_hang       = '0;
      t_follow     = '0;
      p_mode       = MODE_IDLE;
   endfunction

   function automatic rsp_type follow_predict(input req_type ev);
      rsp_type  r;
      mode_type was;
      tick_t    fol;
      r   = '0;
      was = p_mode;
      case (ev.action)
         ACT_TICK: begin
            t_tune    = sat_inc(t_tune);
            t_voice   = sat_inc(t_voice);
            t_hang    = sat_inc(t_hang);
            t_follow  = sat_inc(t_follow);
            t_release = sat_inc(t_release);
            case (p_mode)
               MODE_ARMED: begin
                  if (lapsed(seen_tune, t_tune, follow_cfg.grant_timeout_ticks) &&
                      p_busy == '0) begin
                     drop_call();
                     r.returned_to_cc = 1'b1;
                  end
               end
               MODE_FOLLOW: begin
                  fol = seen_follow ? t_follow : '0;
                  if (lapsed(seen_tune, t_tune, follow_cfg.grace_ticks) &&
                      lapsed(seen_voice, t_voice, follow_cfg.hang_ticks) &&
                      fol >= follow_cfg.dwell_ticks && p_busy == '0) begin
                     drop_call();
                     r.returned_to_cc = 1'b1;
                  end
               end
               MODE_HANG: begin
                  if (lapsed(seen_hang, t_hang, follow_cfg.hang_ticks)) begin
                     drop_call();
                     r.returned_to_cc = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ACT_GRANT: begin
            if (seen_release && p_rel_freq != '0 && ev.freq != '0 &&
                ev.freq == p_rel_freq && t_release < follow_cfg.backoff_ticks) begin
               r.grant_ignored = 1'b1;
            end else begin
               p_call_freq = ev.freq;
               t_tune      = '0;
               seen_tune   = 1'b1;
               t_voice     = '0;
               seen_voice  = 1'b0;
               p_busy      = '0;
               if (ev.freq != '0) begin
                  r.tune_request = 1'b1;
                  r.tune_freq    = ev.freq;
                  r.tune_channel = ev.channel;
               end
               p_mode = MODE_ARMED;
            end
         end
         ACT_VOICE: begin
            if (!ev.slot[1]) p_busy[ev.slot[0]] = 1'b1;
            t_voice    = '0;
            seen_voice = 1'b1;
            if (p_mode == MODE_ARMED || p_mode == MODE_HANG) begin
               p_mode      = MODE_FOLLOW;
               t_follow    = '0;
               seen_follow = 1'b1;
            end
         end
         ACT_QUIET: begin
            if (!ev.slot[1]) p_busy[ev.slot[0]] = 1'b0;
            if (p_busy == '0) begin
               t_hang    = '0;
               seen_hang = 1'b1;
               p_mode    = MODE_HANG;
            end
         end
         ACT_SYNC_LOST: begin
            if ((p_mode == MODE_FOLLOW || p_mode == MODE_ARMED) &&
                lapsed(seen_tune, t_tune, follow_cfg.grace_ticks) && p_busy == '0) begin
               t_hang    = '0;
               seen_hang = 1'b1;
               p_mode    = MODE_HANG;
            end
         end
         default: ;
      endcase
      r.mode         = p_mode;
      r.mode_changed = (p_mode != was);
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic req_type beat_of(input logic [ACTION_BITS-1:0] act,
                                       input logic [CHAN_BITS-1:0] chan,
                                       input logic [FREQ_FIELD_BITS-1:0] freq,
                                       input logic [SLOT_BITS-1:0] slot);
      req_type r;
      r.action  = act;
      r.channel = chan;
      r.freq    = freq;
      r.slot    = slot;
      return r;
   endfunction

   function automatic rsp_type outcome(input mode_type m, input bit chg, input bit tune,
                                       input logic [FREQ_FIELD_BITS-1:0] f,
                                       input logic [CHAN_BITS-1:0] c,
                                       input bit ret, input bit ign);
      rsp_type r;
      r.mode           = m;
      r.mode_changed   = chg;
      r.tune_request   = tune;
      r.tune_freq      = f;
      r.tune_channel   = c;
      r.returned_to_cc = ret;
      r.grant_ignored  = ign;
      return r;
   endfunction

   function automatic plan_row plan_entry(input logic [ACTION_BITS-1:0] act,
                                          input logic [CHAN_BITS-1:0] chan,
                                          input logic [FREQ_FIELD_BITS-1:0] freq,
                                          input logic [SLOT_BITS-1:0] slot,
                                          input int count, input bit typed,
                                          input rsp_type want);
      plan_row p;
      p.act   = act;
      p.chan  = chan;
      p.freq  = freq;
      p.slot  = slot;
      p.count = count;
      p.typed = typed;
      p.want  = want;
      return p;
   endfunction

   // A few frequencies recur so that regrants hit the backoff window
   function automatic logic [FREQ_FIELD_BITS-1:0] pick_freq();
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return SAT_FREQ;
         3, 4:    return 32'h1CA1_8C10;
         5, 6:    return 32'h3B9A_CA00;
         default: return $urandom;
      endcase
   endfunction

   // Slots 0 and 1 mostly, the no-slot codes now and then
   function automatic logic [SLOT_BITS-1:0] pick_slot();
      return SLOT_BITS'(($urandom_range(9) < 8) ? $urandom_range(1) : $urandom_range(2, 3));
   endfunction

   function automatic cfg_type rand_cfg(input int unsigned hi);
      cfg_type c;
      c.hang_ticks          = CFG_BITS'($urandom_range(hi));
      c.grace_ticks         = CFG_BITS'($urandom_range(hi));
      c.dwell_ticks         = CFG_BITS'($urandom_range(hi));
      c.grant_timeout_ticks = CFG_BITS'($urandom_range(hi));
      c.backoff_ticks       = CFG_BITS'($urandom_range(hi));
      return c;
   endfunction

   // Offer one beat, hold it until taken, then log what it should produce
   task automatic push_event(input req_type ev, input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = follow_predict(ev);
      outcome_q.push_back(typed ? want : predicted);
      sent_in_phase++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_HANG_TICKS:     follow_cfg.hang_ticks          = value;
         CSR_GRACE_TICKS:    follow_cfg.grace_ticks         = value;
         CSR_DWELL_TICKS:    follow_cfg.dwell_ticks         = value;
         CSR_GRANT_TO_TICKS: follow_cfg.grant_timeout_ticks = value;
         CSR_BACKOFF_TICKS:  follow_cfg.backoff_ticks       = value;
         default: ;
      endcase
   endtask

   // Load every register back to back, plus one write to an unmapped index
   task automatic load_regs(input cfg_type c);
      write_reg(CSR_HANG_TICKS, c.hang_ticks);
      write_reg(CSR_GRACE_TICKS, c.grace_ticks);
      write_reg(CSR_DWELL_TICKS, c.dwell_ticks);
      write_reg(CSR_GRANT_TO_TICKS, c.grant_timeout_ticks);
      write_reg(CSR_BACKOFF_TICKS, c.backoff_ticks);
      write_reg(CSR_INDEX_BITS'($urandom_range(CSR_COUNT, CSR_SPARE_TOP)),
                CFG_BITS'($urandom));
      csr_we <= 1'b0;
   endtask

   // Drop valid and wait for every outstanding result, bounded
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (outcome_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic tick_burst(input int n);
      repeat (n)
         push_event(beat_of(ACT_TICK, CHAN_BITS'($urandom), $urandom,
                            SLOT_BITS'($urandom)), 1'b0, '0);
   endtask

   // One call: grant, voice on some slots, ticks, slots going quiet, now and then
   // a lost sync, more ticks. Now and then just noise with every field random.
   task automatic run_call();
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 3))
            push_event(beat_of(ACTION_BITS'($urandom_range(ACT_SPARE_HI)),
                               CHAN_BITS'($urandom), $urandom, SLOT_BITS'($urandom)),
                       1'b0, '0);
      end else begin
         push_event(beat_of(ACT_GRANT, CHAN_BITS'($urandom), pick_freq(), pick_slot()),
                    1'b0, '0);
         repeat ($urandom_range(0, 3))
            push_event(beat_of(ACT_VOICE, CHAN_BITS'($urandom), $urandom, pick_slot()),
                       1'b0, '0);
         tick_burst($urandom_range(0, 12));
         repeat ($urandom_range(0, 2))
            push_event(beat_of(ACT_QUIET, CHAN_BITS'($urandom), $urandom, pick_slot()),
                       1'b0, '0);
         if ($urandom_range(3) == 0)
            push_event(beat_of(ACT_SYNC_LOST, CHAN_BITS'($urandom), $urandom, pick_slot()),
                       1'b0, '0);
         tick_burst($urandom_range(0, 25));
      end
   endtask

   task automatic run_phase(input cfg_type c, input int unsigned idle_pct,
                            input int unsigned stall_pct, input bit hold);
      load_regs(c);
      send_idle_pct = idle_pct;
      rsp_stall_pct <= stall_pct;
      if (hold) hold_ask <= 1'b1;
      sent_in_phase = 0;
      while (sent_in_phase < PHASE_ITEMS) run_call();
      settle();
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall, one long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_ask && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Compare each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: result beat with nothing expected", $time);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_data.mode !== want.mode ||
                rsp_data.mode_changed !== want.mode_changed ||
                rsp_data.tune_request !== want.tune_request ||
                rsp_data.tune_freq !== want.tune_freq ||
                rsp_data.tune_channel !== want.tune_channel ||
                rsp_data.returned_to_cc !== want.returned_to_cc ||
                rsp_data.grant_ignored !== want.grant_ignored) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"%0t: mismatch (exp/got) mode %0d/%0d chg %0b/%0b tune %0b/%0b",
                            " freq %h/%h chan %h/%h ret %0b/%0b ign %0b/%0b"},
                           $time, want.mode, rsp_data.mode,
                           want.mode_changed, rsp_data.mode_changed,
                           want.tune_request, rsp_data.tune_request,
                           want.tune_freq, rsp_data.tune_freq,
                           want.tune_channel, rsp_data.tune_channel,
                           want.returned_to_cc, rsp_data.returned_to_cc,
                           want.grant_ignored, rsp_data.grant_ignored);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      cfg_type c;
      int      i, k;

      // Shadow state out of reset
      follow_cfg.hang_ticks          = HANG_TICKS_RST;
      follow_cfg.grace_ticks         = GRACE_TICKS_RST;
      follow_cfg.dwell_ticks         = DWELL_TICKS_RST;
      follow_cfg.grant_timeout_ticks = GRANT_TO_TICKS_RST;
      follow_cfg.backoff_ticks       = BACKOFF_TICKS_RST;
      p_mode       = MODE_IDLE;
      p_busy       = '0;
      p_call_freq  = '0;
      p_rel_freq   = '0;
      t_tune       = '0;
      t_voice      = '0;
      t_hang       = '0;
      t_follow     = '0;
      t_release    = '0;
      seen_tune    = 1'b0;
      seen_voice   = 1'b0;
      seen_hang    = 1'b0;
      seen_follow  = 1'b0;
      seen_release = 1'b0;

      // Directed walk at reset settings (hang 10, grace 15, dwell 7, backoff 10).
      // Typed rows are obvious from the state; the rest go through the shadow.
      dir_plan[0]  = plan_entry(ACT_TICK, '0, '0, '0, 1, 1,
                                outcome(MODE_IDLE, 0, 0, '0, '0, 0, 0));
      dir_plan[1]  = plan_entry(ACT_SPARE_HI, '1, '1, NO_SLOT, 1, 1,
                                outcome(MODE_IDLE, 0, 0, '0, '0, 0, 0));
      // quiet with both slots clear drops to hang even from idle
      dir_plan[2]  = plan_entry(ACT_QUIET, '0, '0, NO_SLOT, 1, 1,
                                outcome(MODE_HANG, 1, 0, '0, '0, 0, 0));
      // the tenth tick runs out the hang timer and releases
      dir_plan[3]  = plan_entry(ACT_TICK, '0, '0, '0, 10, 0, '0);
      // released frequency is zero, so no backoff on a full-scale grant
      dir_plan[4]  = plan_entry(ACT_GRANT, '1, '1, NO_SLOT, 1, 1,
                                outcome(MODE_ARMED, 1, 1, '1, '1, 0, 0));
      dir_plan[5]  = plan_entry(ACT_VOICE, '0, '0, 2'd0, 1, 1,
                                outcome(MODE_FOLLOW, 1, 0, '0, '0, 0, 0));
      dir_plan[6]  = plan_entry(ACT_VOICE, '0, '0, 2'd1, 1, 1,
                                outcome(MODE_FOLLOW, 0, 0, '0, '0, 0, 0));
      dir_plan[7]  = plan_entry(ACT_SPARE_LO, '1, '1, '1, 1, 1,
                                outcome(MODE_FOLLOW, 0, 0, '0, '0, 0, 0));
      dir_plan[8]  = plan_entry(ACT_QUIET, '0, '0, 2'd0, 1, 1,
                                outcome(MODE_FOLLOW, 0, 0, '0, '0, 0, 0));
      // no-slot quiet leaves slot 1 busy
      dir_plan[9]  = plan_entry(ACT_QUIET, '0, '0, 2'd2, 1, 1,
                                outcome(MODE_FOLLOW, 0, 0, '0, '0, 0, 0));
      // still inside the grace window after tuning
      dir_plan[10] = plan_entry(ACT_SYNC_LOST, '0, '0, '0, 1, 1,
                                outcome(MODE_FOLLOW, 0, 0, '0, '0, 0, 0));
      dir_plan[11] = plan_entry(ACT_QUIET, '0, '0, 2'd1, 1, 1,
                                outcome(MODE_HANG, 1, 0, '0, '0, 0, 0));
      // voice in hang resumes following without marking a slot
      dir_plan[12] = plan_entry(ACT_VOICE, '0, '0, NO_SLOT, 1, 1,
                                outcome(MODE_FOLLOW, 1, 0, '0, '0, 0, 0));
      dir_plan[13] = plan_entry(ACT_TICK, '0, '0, '0, 15, 0, '0);
      dir_plan[14] = plan_entry(ACT_TICK, '0, '0, '0, 2, 0, '0);
      // regrant to the just-released frequency inside backoff
      dir_plan[15] = plan_entry(ACT_GRANT, '0, '1, 2'd0, 1, 1,
                                outcome(MODE_IDLE, 0, 0, '0, '0, 0, 1));
      // grant with no frequency arms but asks for no tune
      dir_plan[16] = plan_entry(ACT_GRANT, 16'h1234, '0, 2'd1, 1, 1,
                                outcome(MODE_ARMED, 1, 0, '0, '0, 0, 0));
      dir_plan[17] = plan_entry(ACT_SYNC_LOST, '0, '0, '0, 1, 0, '0);
      dir_plan[18] = plan_entry(ACT_SPARE_MID, '0, '0, '0, 1, 1,
                                outcome(MODE_ARMED, 0, 0, '0, '0, 0, 0));
      dir_plan[19] = plan_entry(ACT_GRANT, 16'h00A5, 32'h5A5A_0001, 2'd2, 1, 1,
                                outcome(MODE_ARMED, 0, 1, 32'h5A5A_0001, 16'h00A5, 0, 0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++)
         for (k = 1; k <= dir_plan[i].count; k++)
            push_event(beat_of(dir_plan[i].act, dir_plan[i].chan, dir_plan[i].freq,
                               dir_plan[i].slot),
                       dir_plan[i].typed && k == dir_plan[i].count, dir_plan[i].want);
      settle();

      // Full-scale registers: release with a zero hang time, tick a few times,
      // then regrant the same frequency while the full-scale backoff window is
      // still open, then lose sync while idle.
      c = '{hang_ticks: '0, default: '1};
      load_regs(c);
      push_event(beat_of(ACT_GRANT, 16'h0042, SAT_FREQ, 2'd0), 1'b0, '0);
      push_event(beat_of(ACT_QUIET, '0, '0, 2'd2), 1'b0, '0);
      tick_burst(1);
      tick_burst(BACKOFF_GAP);
      push_event(beat_of(ACT_GRANT, 16'h0043, SAT_FREQ, 2'd1), 1'b0, '0);
      push_event(beat_of(ACT_SYNC_LOST, '0, '0, '0), 1'b0, '0);
      settle();

      // Random phases: no idling at the zero extreme, then sender gaps, then
      // receiver stalls with one long hold-off so the input backs up, then both
      run_phase('0, 0, 0, 1'b0);
      run_phase(rand_cfg(20), 64, 0, 1'b0);
      run_phase(rand_cfg(30), 0, 64, 1'b1);
      c = rand_cfg(40);
      c.hang_ticks = '1;
      run_phase(c, 22, 22, 1'b0);

      mismatches += outcome_q.size();
      if (mismatches == 0)
         $display("trunk_voice_follow_fsm_core_tb passed");
      else
         $display("trunk_voice_follow_fsm_core_tb failed");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/tvf_pkg.sv
hw/rtl/tvf_csr.sv
hw/rtl/tvf_engine.sv
hw/rtl/trunk_voice_follow_fsm_core.sv
dv/trunk_voice_follow_fsm_core_tb.sv
